// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the servo pulse decoder checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/spmd_pkg.sv
// ----------------------------------------------------------------------------
// spmd_pkg
// shared types and constants of the servo pulse median decoder
// ----------------------------------------------------------------------------
package spmd_pkg;

	// stream word widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int SERVO_W     = 8;

	// zero offset after reset, one millisecond in ticks
	localparam logic [SERVO_W-1:0] ZERO_OFFSET_RST = 8'd125;
	// largest servo value
	localparam logic [SERVO_W-1:0] SERVO_MAX = 8'hFF;

	// result word, servo_value in the lowest bits
	typedef struct packed {
		logic               pulse_done;
		logic               ready_res;
		logic [SERVO_W-1:0] servo_value;
	} res_word_t;

	localparam int RES_W = $bits(res_word_t);

endpackage

// File: rtl/core/spmd_front.sv
// ----------------------------------------------------------------------------
// spmd_front
// edge detection and pulse tick counter; classifies each sample word
// ----------------------------------------------------------------------------
module spmd_front
	import spmd_pkg::*;
#(
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  pin_level,
	input  logic                  tick,
	output logic                  push,
	output logic [COUNT_BITS:0]   push_data
);

	logic                  last_level_q;
	logic                  counting_q;
	logic [COUNT_BITS-1:0] pulse_count_q;
	logic                  rise;
	logic                  fall;

	// edges against the previous sample
	assign rise = pin_level & ~last_level_q;
	assign fall = ~pin_level & last_level_q;
	assign push = in_valid & in_ready;

	// queue entry: end-of-pulse flag over the count before this sample
	assign push_data = {fall, pulse_count_q};

	// counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b0;
			counting_q    <= 1'b0;
			pulse_count_q <= '0;
		end else if (push) begin
			last_level_q <= pin_level;
			if (rise) begin
				pulse_count_q <= '0;
				counting_q    <= 1'b1;
			end else if (fall) begin
				counting_q <= 1'b0;
			end else if (counting_q && tick) begin
				pulse_count_q <= pulse_count_q + COUNT_BITS'(1);
			end
		end
	end

endmodule

// File: rtl/core/spmd_queue.sv
// ----------------------------------------------------------------------------
// spmd_queue
// two-entry queue between front and back parts
// ----------------------------------------------------------------------------
module spmd_queue #(
	parameter int W = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         not_full,
	output logic         not_empty,
	output logic [W-1:0] head
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign not_full  = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/core/spmd_back.sv
// ----------------------------------------------------------------------------
// spmd_back
// width ring, rank-select upper median and offset subtract with output register
// ----------------------------------------------------------------------------
module spmd_back
	import spmd_pkg::*;
#(
	parameter int RING_DEPTH = 4,
	parameter int COUNT_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [COUNT_BITS:0] q_data,
	output logic                q_pop,
	input  logic [SERVO_W-1:0]  zero_offset,
	input  logic                out_ready,
	output logic                out_valid,
	output res_word_t           out_word
);

	localparam int SLOT_W   = $clog2(RING_DEPTH);
	localparam int FILL_W   = $clog2(RING_DEPTH + 1);
	localparam int MED_RANK = RING_DEPTH / 2;

	logic [COUNT_BITS-1:0] width_ring [RING_DEPTH];
	logic [SLOT_W-1:0]     write_slot_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  adv;
	logic                  ring_full;

	logic                  valid_s1;
	logic                  done_s1;
	logic                  valid_s2;
	logic                  done_s2;
	logic                  ready_s2;
	logic [COUNT_BITS-1:0] med_s2;

	logic [SLOT_W-1:0]     rank [RING_DEPTH];
	logic [COUNT_BITS-1:0] med;
	logic [COUNT_BITS-1:0] offset_ext;
	logic [COUNT_BITS-1:0] diff;
	logic [SERVO_W-1:0]    value;
	logic                  out_valid_q;
	res_word_t             out_word_q;

	// whole pipeline moves when the output register can take a word
	assign adv       = !out_valid_q || out_ready;
	assign q_pop     = adv && q_valid;
	assign ring_full = (fill_q == FILL_W'(RING_DEPTH));

	// ring write at the pop of an end-of-pulse entry
	always_ff @(posedge clk) begin
		if (q_pop && q_data[COUNT_BITS]) begin
			width_ring[write_slot_q] <= q_data[COUNT_BITS-1:0];
		end
	end

	// ring slot, fill level and stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			fill_q       <= '0;
			valid_s1     <= 1'b0;
			done_s1      <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			done_s1  <= q_valid && q_data[COUNT_BITS];
			if (q_valid && q_data[COUNT_BITS]) begin
				if (write_slot_q == SLOT_W'(RING_DEPTH - 1)) begin
					write_slot_q <= '0;
				end else begin
					write_slot_q <= write_slot_q + SLOT_W'(1);
				end
				if (!ring_full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// rank of each entry, ties broken by slot, then pick the upper median
	always_comb begin
		med = width_ring[0];
		for (int i = 0; i < RING_DEPTH; i++) begin
			rank[i] = '0;
			for (int j = 0; j < RING_DEPTH; j++) begin
				if (j != i) begin
					if (width_ring[j] < width_ring[i] ||
						(j < i && width_ring[j] == width_ring[i])) begin
						rank[i] = rank[i] + SLOT_W'(1);
					end
				end
			end
		end
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (rank[i] == SLOT_W'(MED_RANK)) begin
				med = width_ring[i];
			end
		end
	end

	// stage two control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			done_s2  <= 1'b0;
			ready_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			done_s2  <= done_s1;
			ready_s2 <= ring_full;
		end
	end

	// stage two median
	always_ff @(posedge clk) begin
		if (adv) begin
			med_s2 <= med;
		end
	end

	// offset subtract, clamp at zero, saturate to the servo range; zero until the ring is full
	assign offset_ext = COUNT_BITS'(zero_offset);
	assign diff       = med_s2 - offset_ext;
	always_comb begin
		if (!ready_s2 || med_s2 < offset_ext) begin
			value = '0;
		end else if (diff > COUNT_BITS'(SERVO_MAX)) begin
			value = SERVO_MAX;
		end else begin
			value = diff[SERVO_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q.servo_value <= value;
			out_word_q.ready_res   <= ready_s2;
			out_word_q.pulse_done  <= done_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// File: rtl/core/servo_pulse_median_decoder_unit.sv
// An accepted sample word passes the queue, stage one, stage two and output register.
// Throughput: one sample word per cycle unless stalled; the median rank compare and the
// offset subtract each hold one pipeline stage; a two-entry queue decouples the counter.
// Reset (arst_n low, asynchronous) stops the counter, empties the queue and ring
// fill level, and sets zero_offset to 125; ring contents are not cleared.
// ----------------------------------------------------------------------------
// servo_pulse_median_decoder_unit
// servo pulse width decoder with upper-median filter over the last pulses
// ----------------------------------------------------------------------------
module servo_pulse_median_decoder_unit
	import spmd_pkg::*;
#(
	parameter int RING_DEPTH = 4,
	parameter int COUNT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // pin_level, tick
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // servo_value[7:0], ready_res, pulse_done
	input  logic                   cfg_wen,
	input  logic [SERVO_W-1:0]     cfg_wdata
);

	logic                  push;
	logic [COUNT_BITS:0]   push_data;
	logic                  q_not_full;
	logic                  q_not_empty;
	logic [COUNT_BITS:0]   q_head;
	logic                  q_pop;
	logic [SERVO_W-1:0]    zero_offset_q;
	res_word_t             out_word;

	// zero offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= ZERO_OFFSET_RST;
		end else if (cfg_wen) begin
			zero_offset_q <= cfg_wdata;
		end
	end

	assign s_tready = q_not_full;

	spmd_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (q_not_full),
		.pin_level (s_tdata[0]),
		.tick      (s_tdata[1]),
		.push      (push),
		.push_data (push_data)
	);

	spmd_queue #(
		.W(COUNT_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.not_full  (q_not_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	spmd_back #(
		.RING_DEPTH(RING_DEPTH),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_data      (q_head),
		.q_pop       (q_pop),
		.zero_offset (zero_offset_q),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_word    (out_word)
	);

	assign m_tdata = {(OUT_TDATA_W - RES_W)'(0), out_word};

endmodule

// File: rtl/core/spmd_checker.sv
// ----------------------------------------------------------------------------
// spmd_checker
// port-level checks of the servo pulse median decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spmd_checker
	import spmd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata
);

	logic prev_ready_q;

	// ready flag of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ready_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			prev_ready_q <= m_tdata[SERVO_W];
		end
	end

	// a stalled word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result word changed")

	// no value before the ring is full
	`ASSERT_IMPL(a_zero_until_ready, clk, arst_n, m_tvalid && !m_tdata[SERVO_W], m_tdata[SERVO_W-1:0] == '0, "servo value nonzero while ring not full")

	// ring full only turns on with a finished pulse
	`ASSERT_IMPL(a_ready_needs_pulse, clk, arst_n, m_tvalid && m_tdata[SERVO_W] && !prev_ready_q, m_tdata[SERVO_W+1], "ring became full without a pulse")

	// once full, the ring stays full
	`ASSERT_IMPL(a_ready_sticky, clk, arst_n, m_tvalid && prev_ready_q, m_tdata[SERVO_W], "ready flag dropped")

endmodule

bind servo_pulse_median_decoder_unit spmd_checker u_spmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/tb_servo_pulse_median_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_servo_pulse_median_decoder_unit
// Streams pin samples into the servo pulse decoder and checks every result
// word against a local model of the edge detector, the pulse counter, the
// four-entry width ring and the upper-median offset stage. The zero offset
// is changed between phases. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_servo_pulse_median_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import spmd_pkg::*;

	localparam int RING_SLOTS  = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 8;
	localparam int PRINT_CAP   = 40;

	// one pin sample, pin level in the lowest bit
	typedef struct packed {
		logic tick;
		logic level;
	} pin_sample_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // pin_level, tick
	logic                   m_tready  = 1'b0;
	logic                   cfg_wen   = 1'b0;
	logic [SERVO_W-1:0]     cfg_wdata = '0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;          // servo_value[7:0], ready_res, pulse_done

	pin_sample_t pin_q[$];
	res_word_t   servo_expect_q[$];
	int          err_cnt      = 0;
	int          accepted_cnt = 0;
	int          queued_cnt   = 0;
	int          cycle_cnt    = 0;

	// decoder model state
	logic [SERVO_W-1:0] zero_offset_m = ZERO_OFFSET_RST;
	logic               last_level_m  = 1'b0;
	logic               counting_m    = 1'b0;
	logic [7:0]         width_cnt_m   = '0;
	logic [7:0]         ring_m [RING_SLOTS];
	logic [1:0]         slot_m        = '0;
	int                 fill_m        = 0;

	// stall-free window in the middle of the run
	wire calm = (accepted_cnt >= 900) && (accepted_cnt < 1250);

	always #4 clk = ~clk;

	servo_pulse_median_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// advance the pulse decoder by one sample, return the expected word
	function automatic res_word_t track_pulse(pin_sample_t smp);
		logic [7:0] srt [RING_SLOTS];
		logic [7:0] v;
		res_word_t  r;
		int         j;
		r = '0;
		if (smp.level && !last_level_m) begin
			width_cnt_m = '0;
			counting_m  = 1'b1;
		end else if (!smp.level && last_level_m) begin
			counting_m     = 1'b0;
			ring_m[slot_m] = width_cnt_m;
			slot_m         = slot_m + 2'd1;
			if (fill_m < RING_SLOTS)
				fill_m++;
			r.pulse_done = 1'b1;
		end else if (counting_m && smp.tick) begin
			width_cnt_m = width_cnt_m + 8'd1;
		end
		last_level_m = smp.level;
		// upper median of the ring once every slot holds a pulse
		if (fill_m == RING_SLOTS) begin
			r.ready_res = 1'b1;
			srt = ring_m;
			for (int i = 1; i < RING_SLOTS; i++) begin
				v = srt[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			v = srt[RING_SLOTS/2];
			r.servo_value = (v < zero_offset_m) ? '0 : v - zero_offset_m;
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		err_cnt++;
		if (err_cnt <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	// sample word driver
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pin_q.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= IN_TDATA_W'(pin_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result word monitor and model update
	always @(posedge clk) begin : mon
		res_word_t got_w;
		res_word_t want_w;
		if (arst_n) begin
			m_tready <= calm || ($urandom_range(99) >= 13);
			if (m_tvalid && m_tready) begin
				got_w = res_word_t'(m_tdata[RES_W-1:0]);
				if (servo_expect_q.size() == 0) begin
					report_mismatch($sformatf("result word %h with none expected", m_tdata));
				end else begin
					want_w = servo_expect_q.pop_front();
					if (got_w.servo_value != want_w.servo_value)
						report_mismatch($sformatf("servo_value %0d, expected %0d",
							got_w.servo_value, want_w.servo_value));
					if (got_w.ready_res != want_w.ready_res)
						report_mismatch($sformatf("ready_res %0d, expected %0d",
							got_w.ready_res, want_w.ready_res));
					if (got_w.pulse_done != want_w.pulse_done)
						report_mismatch($sformatf("pulse_done %0d, expected %0d",
							got_w.pulse_done, want_w.pulse_done));
				end
			end
			if (s_tvalid && s_tready) begin
				servo_expect_q.push_back(track_pulse(pin_sample_t'(s_tdata[1:0])));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic put_sample(logic level, logic tick);
		pin_sample_t s;
		s.level = level;
		s.tick  = tick;
		pin_q.push_back(s);
		queued_cnt++;
	endtask

	// low gap, rising edge, ticks counted with some tick-less samples, falling edge
	task automatic put_pulse(int ticks, int gap, int hole_pct);
		int n;
		n = 0;
		for (int i = 0; i < gap; i++)
			put_sample(1'b0, 1'($urandom_range(1)));
		put_sample(1'b1, 1'($urandom_range(1)));
		while (n < ticks) begin
			if ($urandom_range(99) < hole_pct) begin
				put_sample(1'b1, 1'b0);
			end else begin
				put_sample(1'b1, 1'b1);
				n++;
			end
		end
		put_sample(1'b0, 1'($urandom_range(1)));
	endtask

	// mostly short pulses, some near one millisecond, a few wrapping the counter
	task automatic put_random_pulse();
		int pick;
		int ticks;
		pick = $urandom_range(9);
		if (pick < 5)
			ticks = $urandom_range(40);
		else if (pick < 9)
			ticks = $urandom_range(90, 160);
		else
			ticks = $urandom_range(300);
		// glitchy level bursts now and then
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(1, 5))
				put_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
		end
		put_pulse(ticks, $urandom_range(8), 20);
	endtask

	task automatic wait_idle();
		while (pin_q.size() != 0 || s_tvalid || servo_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_offset(logic [SERVO_W-1:0] v);
		@(posedge clk);
		cfg_wen       <= 1'b1;
		cfg_wdata     <= v;
		zero_offset_m  = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// stimulus phases
	initial begin
		int base;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// edge and tick corner cases at the reset offset
		put_sample(1'b0, 1'b1);   // tick while stopped
		put_sample(1'b0, 1'b1);
		put_sample(1'b1, 1'b1);   // tick on the rising edge is not counted
		put_sample(1'b1, 1'b1);
		put_sample(1'b1, 1'b0);
		put_sample(1'b1, 1'b1);
		put_sample(1'b0, 1'b1);   // tick on the falling edge is not counted
		put_sample(1'b1, 1'b0);   // one-sample pulse, width zero
		put_sample(1'b0, 1'b0);
		put_sample(1'b1, 1'b1);
		put_sample(1'b1, 1'b1);
		put_sample(1'b1, 1'b1);
		put_sample(1'b0, 1'b0);
		put_sample(1'b1, 1'b0);
		put_sample(1'b1, 1'b1);
		put_sample(1'b0, 1'b1);   // ring full here
		put_sample(1'b0, 1'b1);
		put_sample(1'b0, 1'b0);

		// zero offset: full-scale median, then a counter wrap
		wait_idle();
		write_offset(8'd0);
		put_pulse(255, 2, 0);
		put_pulse(255, 1, 0);
		put_pulse(3, 0, 0);
		put_pulse(7, 3, 0);
		put_pulse(256, 2, 0);
		repeat (5) put_pulse($urandom_range(40), $urandom_range(8), 25);

		// largest offset clamps everything to zero
		wait_idle();
		write_offset(SERVO_MAX);
		repeat (4) put_random_pulse();

		// random offsets and pulse trains
		for (int k = 0; k < 3; k++) begin
			wait_idle();
			if (k == 0)
				write_offset(8'($urandom_range(100, 150)));
			else if (k == 1)
				write_offset(8'($urandom_range(1, 40)));
			else
				write_offset(8'($urandom_range(254)));
			base = queued_cnt;
			while (queued_cnt < base + 30)
				put_random_pulse();
		end

		wait_idle();
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
